FILE: src/rsi_pkg.sv
// Shared constants and types for the ray / sphere intersection unit.
// No dependencies; every other file of the block but rsi_sqrt_cell refers to this package.
package rsi_pkg;

  // Default coordinate width and fraction bits of the fixed-point format.
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FracBitsDef   = 16;

  // Width of the distance field and its saturation value.
  localparam int unsigned DistW = 31;
  localparam logic [DistW-1:0] DistMax = '1;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    RegCenterX = 2'd0,
    RegCenterY = 2'd1,
    RegCenterZ = 2'd2,
    RegRadius  = 2'd3
  } cfg_reg_e;

endpackage

FILE: src/ray_sphere_intersect_unit.sv
// Top level of the ray / sphere intersection unit.
// Depends on rsi_pkg, rsi_front, rsi_sqrt_cell and rsi_div_cell.
//
// Usage: each transaction on the s_axis channel carries one ray (origin and
// direction, signed fixed point). Each ray yields exactly one transaction on
// the m_axis channel: hit in tuser, nearer distance and saturation flag in
// tdata. The sphere center and radius are written over the cfg channel, which
// is always ready; write it only while no ray is in flight.
// Throughput: one ray per cycle while the output is not stalled. Pipeline: 6 front
// stages, then a chain of 2*COORD_WIDTH+1+FRAC_BITS square root cells, one subtract
// stage, a chain of 32 divider cells and the output register. The length of the
// square root cell row dominates the latency; every cell settles one root bit.
// Reset clears all valid bits and loads the configuration reset values
// (center at the origin, radius 1.0). When the receiver stalls, the output
// register plus a skid register absorb the result; once the skid register
// holds data, s_axis_tready drops and the whole pipeline holds still.
module ray_sphere_intersect_unit #(
  parameter int unsigned COORD_WIDTH = rsi_pkg::CoordWidthDef,
  parameter int unsigned FRAC_BITS   = rsi_pkg::FracBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input rays: tdata = origin_x, origin_y, origin_z, dir_x, dir_y, dir_z.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  // Results: tdata = distance, saturated; tuser = hit.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((rsi_pkg::DistW+8)/8)*8-1:0] m_axis_tdata,
  output logic                                m_axis_tuser,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rsi_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [COORD_WIDTH-1:0]              cfg_data_i
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned AW    = 2 * CW;
  localparam int unsigned HW    = 2 * CW + 1;
  localparam int unsigned DW    = 4 * CW + 2;
  localparam int unsigned XW    = DW + 2 * FRAC_BITS;
  localparam int unsigned RW    = XW / 2;
  localparam int unsigned NW    = HW + FRAC_BITS;
  localparam int unsigned PayW  = 1 + HW + AW;
  localparam int unsigned QW    = rsi_pkg::DistW + 1;
  localparam int unsigned OutW  = ((rsi_pkg::DistW + 8) / 8) * 8;
  localparam logic [CW-2:0] RadiusRst = (CW-1)'(64'd1 << FRAC_BITS);

  logic en;

  // Configuration registers.
  logic [2:0][CW-1:0] center_q;
  logic [CW-2:0]      radius_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      radius_q <= RadiusRst;
    end else if (cfg_valid_i) begin
      unique case (rsi_pkg::cfg_reg_e'(cfg_index_i))
        rsi_pkg::RegCenterX: center_q[0] <= cfg_data_i;
        rsi_pkg::RegCenterY: center_q[1] <= cfg_data_i;
        rsi_pkg::RegCenterZ: center_q[2] <= cfg_data_i;
        rsi_pkg::RegRadius:  radius_q    <= cfg_data_i[CW-2:0];
        default: ;
      endcase
    end
  end

  // Front pipeline up to the discriminant.
  logic          fr_valid;
  logic          fr_miss;
  logic [DW-1:0] fr_disc;
  logic [HW-1:0] fr_s;
  logic [AW-1:0] fr_a;

  assign s_axis_tready = en;

  rsi_front #(
    .CoordWidth (CW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_axis_tvalid),
    .ray_i    (s_axis_tdata[6*CW-1:0]),
    .center_i (center_q),
    .radius_i (radius_q),
    .valid_o  (fr_valid),
    .miss_o   (fr_miss),
    .disc_o   (fr_disc),
    .s_o      (fr_s),
    .a_o      (fr_a)
  );

  // Square root row: one root bit of disc * 4^FRAC_BITS per cell.
  logic            sq_valid [RW+1];
  logic [XW-1:0]   sq_rem   [RW+1];
  logic [XW-1:0]   sq_res   [RW+1];
  logic [PayW-1:0] sq_pay   [RW+1];

  assign sq_valid[0] = fr_valid;
  assign sq_rem[0]   = {fr_disc, (2*FRAC_BITS)'(0)};
  assign sq_res[0]   = '0;
  assign sq_pay[0]   = {fr_miss, fr_s, fr_a};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    rsi_sqrt_cell #(
      .XW    (XW),
      .Shift (XW - 2 - 2 * i),
      .PayW  (PayW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .rem_i   (sq_rem[i]),
      .res_i   (sq_res[i]),
      .pay_i   (sq_pay[i]),
      .valid_o (sq_valid[i+1]),
      .rem_o   (sq_rem[i+1]),
      .res_o   (sq_res[i+1]),
      .pay_o   (sq_pay[i+1])
    );
  end

  // Numerator of the nearer root: s * 2^FRAC_BITS minus the rounded-up root.
  logic          sq_miss;
  logic [HW-1:0] sq_s;
  logic [AW-1:0] sq_a;
  logic          nu_valid_q;
  logic          nu_miss_q;
  logic [NW-1:0] nu_num_q;
  logic [AW-1:0] nu_a_q;

  assign {sq_miss, sq_s, sq_a} = sq_pay[RW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      nu_num_q <= {sq_s, (FRAC_BITS)'(0)} - sq_res[RW][NW-1:0]
                  - NW'(sq_rem[RW] != '0);
      nu_a_q   <= sq_a;
      nu_miss_q <= sq_miss;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nu_valid_q <= 1'b0;
    end else if (en) begin
      nu_valid_q <= sq_valid[RW];
    end
  end

  // Divider row: top cell detects saturation, the others give the distance.
  logic          dv_valid [QW+1];
  logic          dv_miss  [QW+1];
  logic [NW-1:0] dv_rem   [QW+1];
  logic [AW-1:0] dv_den   [QW+1];
  logic [QW-1:0] dv_quo   [QW+1];

  assign dv_valid[0] = nu_valid_q;
  assign dv_miss[0]  = nu_miss_q;
  assign dv_rem[0]   = nu_num_q;
  assign dv_den[0]   = nu_a_q;
  assign dv_quo[0]   = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    rsi_div_cell #(
      .RemW  (NW),
      .DenW  (AW),
      .Shift (QW - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[k]),
      .miss_i  (dv_miss[k]),
      .rem_i   (dv_rem[k]),
      .den_i   (dv_den[k]),
      .quo_i   (dv_quo[k]),
      .valid_o (dv_valid[k+1]),
      .miss_o  (dv_miss[k+1]),
      .rem_o   (dv_rem[k+1]),
      .den_o   (dv_den[k+1]),
      .quo_o   (dv_quo[k+1])
    );
  end

  // Result formatting: clamp on saturation, all zero on a miss.
  logic                      res_sat;
  logic [rsi_pkg::DistW-1:0] res_dist;
  logic [OutW-1:0]           res_data;
  logic                      res_hit;

  always_comb begin
    res_hit  = !dv_miss[QW];
    res_sat  = res_hit && dv_quo[QW][QW-1];
    res_dist = '0;
    if (res_hit) begin
      res_dist = res_sat ? rsi_pkg::DistMax : dv_quo[QW][rsi_pkg::DistW-1:0];
    end
    res_data = OutW'({res_sat, res_dist});
  end

  // Output register with a skid register behind it.
  logic            out_valid_q;
  logic [OutW-1:0] out_data_q;
  logic            out_hit_q;
  logic            skid_valid_q;
  logic [OutW-1:0] skid_data_q;
  logic            skid_hit_q;
  logic            out_fire;

  assign en       = !skid_valid_q;
  assign out_fire = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (dv_valid[QW]) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
        out_hit_q  <= skid_hit_q;
      end
    end else if (dv_valid[QW]) begin
      if (!out_valid_q || out_fire) begin
        out_data_q <= res_data;
        out_hit_q  <= res_hit;
      end else begin
        skid_data_q <= res_data;
        skid_hit_q  <= res_hit;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_hit_q;

endmodule

FILE: src/rsi_front.sv
// Front pipeline: forms a = d.d, h = d.w, c = w.w - r^2 and the discriminant.
// Depends on rsi_pkg. Six register stages, all advancing on en_i.
module rsi_front #(
  parameter int unsigned CoordWidth = rsi_pkg::CoordWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [6*CoordWidth-1:0]     ray_i,     // origin x,y,z then dir x,y,z
  input  logic [2:0][CoordWidth-1:0]  center_i,
  input  logic [CoordWidth-2:0]       radius_i,
  output logic                        valid_o,
  output logic                        miss_o,
  output logic [4*CoordWidth+1:0]     disc_o,
  output logic [2*CoordWidth:0]       s_o,
  output logic [2*CoordWidth-1:0]     a_o
);

  localparam int unsigned CW  = CoordWidth;
  localparam int unsigned WW  = CW + 1;
  localparam int unsigned PW  = 2 * CW + 2;
  localparam int unsigned AW  = 2 * CW;
  localparam int unsigned HW  = 2 * CW + 1;
  localparam int unsigned L   = CW + 1;
  localparam int unsigned DW  = 4 * CW + 2;

  // Stage 1: relative origin w = o - center, direction held.
  logic signed [CW-1:0] d_q [3];
  logic signed [WW-1:0] w_q [3];
  logic [CW-2:0]        r_q;
  logic                 v1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= $signed(ray_i[(3+i)*CW +: CW]);
        w_q[i] <= WW'($signed(ray_i[i*CW +: CW])) - WW'($signed(center_i[i]));
      end
      r_q <= radius_i;
    end
  end

  // Stage 2: per-axis products and r^2.
  logic signed [PW-1:0] dd_q [3];
  logic signed [PW-1:0] dw_q [3];
  logic signed [PW-1:0] ww_q [3];
  logic [AW-3:0]        r2_q;
  logic                 v2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dd_q[i] <= d_q[i] * d_q[i];
        dw_q[i] <= d_q[i] * w_q[i];
        ww_q[i] <= w_q[i] * w_q[i];
      end
      r2_q <= r_q * r_q;
    end
  end

  // Stage 3: sums over the three axes.
  logic [AW-1:0]        a3_q;
  logic signed [PW-1:0] h3_q;
  logic signed [PW:0]   c3_q;
  logic                 v3_q;
  logic signed [PW-1:0] dd_sum;

  assign dd_sum = dd_q[0] + dd_q[1] + dd_q[2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a3_q <= AW'(dd_sum);
      h3_q <= dw_q[0] + dw_q[1] + dw_q[2];
      c3_q <= (PW+1)'(ww_q[0]) + (PW+1)'(ww_q[1]) + (PW+1)'(ww_q[2])
              - (PW+1)'(r2_q);
    end
  end

  // Stage 4: early miss decision and partial products of h^2 and a*c.
  logic                 miss4_d;
  logic [PW-1:0]        hneg;
  logic [HW-1:0]        hm;
  logic [PW-1:0]        cm;
  logic                 miss4_q;
  logic [HW-1:0]        s4_q;
  logic [AW-1:0]        a4_q;
  logic [2*L-1:0]       p_hll_q;
  logic [L+CW-1:0]      p_hlh_q;
  logic [2*CW-1:0]      p_hhh_q;
  logic [2*L-1:0]       p_all_q;
  logic [2*L-1:0]       p_alh_q;
  logic [2*CW-1:0]      p_ahl_q;
  logic [2*CW-1:0]      p_ahh_q;
  logic                 v4_q;

  assign miss4_d = (a3_q == '0) || c3_q[PW] || (c3_q == '0) || !h3_q[PW-1];
  assign hneg    = -h3_q;
  assign hm      = hneg[HW-1:0];
  assign cm      = c3_q[PW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      miss4_q <= miss4_d;
      s4_q    <= hm;
      a4_q    <= a3_q;
      p_hll_q <= hm[L-1:0] * hm[L-1:0];
      p_hlh_q <= hm[L-1:0] * hm[HW-1:L];
      p_hhh_q <= hm[HW-1:L] * hm[HW-1:L];
      p_all_q <= a3_q[L-1:0] * cm[L-1:0];
      p_alh_q <= a3_q[L-1:0] * cm[PW-1:L];
      p_ahl_q <= a3_q[AW-1:L] * cm[L-1:0];
      p_ahh_q <= a3_q[AW-1:L] * cm[PW-1:L];
    end
  end

  // Stage 5: assemble h^2 and a*c from the partial products.
  logic [DW-1:0] h2_q;
  logic [DW-1:0] ac_q;
  logic          miss5_q;
  logic [HW-1:0] s5_q;
  logic [AW-1:0] a5_q;
  logic          v5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h2_q <= DW'(p_hll_q) + (DW'(p_hlh_q) << (L + 1)) + (DW'(p_hhh_q) << (2 * L));
      ac_q <= DW'(p_all_q) + ((DW'(p_alh_q) + DW'(p_ahl_q)) << L)
              + (DW'(p_ahh_q) << (2 * L));
      miss5_q <= miss4_q;
      s5_q    <= s4_q;
      a5_q    <= a4_q;
    end
  end

  // Stage 6: discriminant h^2 - a*c; a negative one is a miss.
  logic [DW:0] disc_diff;

  assign disc_diff = {1'b0, h2_q} - {1'b0, ac_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      disc_o <= disc_diff[DW-1:0];
      miss_o <= miss5_q || disc_diff[DW];
      s_o    <= s5_q;
      a_o    <= a5_q;
    end
  end

  // Valid bits of the six stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      valid_o <= v5_q;
    end
  end

endmodule

FILE: src/rsi_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per cell.
// No package dependency; instantiated in a row by the top level.
module rsi_sqrt_cell #(
  parameter int unsigned XW    = 8,
  parameter int unsigned Shift = 0,
  parameter int unsigned PayW  = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [XW-1:0]   rem_i,
  input  logic [XW-1:0]   res_i,
  input  logic [PayW-1:0] pay_i,
  output logic            valid_o,
  output logic [XW-1:0]   rem_o,
  output logic [XW-1:0]   res_o,
  output logic [PayW-1:0] pay_o
);

  localparam logic [XW:0] TrialBit = (XW+1)'(1) << Shift;

  logic [XW:0]   trial;
  logic          take;
  logic [XW-1:0] rem_d;
  logic [XW-1:0] res_d;

  // Subtract the trial square when it fits and set this root bit.
  always_comb begin
    trial = {1'b0, res_i} + TrialBit;
    take  = {1'b0, rem_i} >= trial;
    rem_d = take ? rem_i - trial[XW-1:0] : rem_i;
    res_d = take ? (res_i >> 1) + TrialBit[XW-1:0] : (res_i >> 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      res_o <= res_d;
      pay_o <= pay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

endmodule

FILE: src/rsi_div_cell.sv
// One cell of the restoring divider chain: settles one quotient bit.
// Depends on rsi_pkg for the quotient width.
module rsi_div_cell #(
  parameter int unsigned RemW  = 8,
  parameter int unsigned DenW  = 8,
  parameter int unsigned Shift = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic                    miss_i,
  input  logic [RemW-1:0]         rem_i,
  input  logic [DenW-1:0]         den_i,
  input  logic [rsi_pkg::DistW:0] quo_i,
  output logic                    valid_o,
  output logic                    miss_o,
  output logic [RemW-1:0]         rem_o,
  output logic [DenW-1:0]         den_o,
  output logic [rsi_pkg::DistW:0] quo_o
);

  localparam int unsigned DV = ((RemW > DenW + Shift) ? RemW : DenW + Shift) + 1;

  logic [DV-1:0]              den_sh;
  logic                       take;
  logic [DV-1:0]              diff;
  logic [rsi_pkg::DistW:0]    quo_d;

  // Compare the remainder with the shifted divisor and subtract on a fit.
  always_comb begin
    den_sh       = DV'(den_i) << Shift;
    take         = DV'(rem_i) >= den_sh;
    diff         = DV'(rem_i) - den_sh;
    quo_d        = quo_i;
    quo_d[Shift] = take;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= take ? diff[RemW-1:0] : rem_i;
      den_o  <= den_i;
      quo_o  <= quo_d;
      miss_o <= miss_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

endmodule

FILE: verif/tb_ray_sphere_intersect_unit.sv
// Self-checking testbench for ray_sphere_intersect_unit: directed rays, then random rays
// under several sphere settings, checked against an exact wide-integer intersection model.
// Depends on rsi_pkg and the unit's RTL.
module tb_ray_sphere_intersect_unit;

  localparam int          CW        = 32;
  localparam int          FB        = 16;
  localparam int          Q         = 65536;
  localparam int          LatencyC  = 2 * CW + FB + 41;
  localparam int          CycleLim  = 600000;
  localparam int          IntMax    = 32'h7fff_ffff;
  localparam int          IntMin    = 32'h8000_0000;

  typedef logic signed [255:0] wide_t;
  typedef logic [5:0][CW-1:0] ray_t;

  typedef struct packed {
    logic                      hit;
    logic [rsi_pkg::DistW-1:0] distance;
    logic                      sat;
  } hit_res_t;

  typedef struct {
    ray_t     ray;
    bit       known;
    hit_res_t res;
  } ray_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [6*CW-1:0]             s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [31:0]                 m_axis_tdata;
  logic                        m_axis_tuser;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [rsi_pkg::CfgIdxW-1:0] cfg_index_i = rsi_pkg::RegCenterX;
  logic [CW-1:0]               cfg_data_i = '0;

  // Sphere setting as the model sees it.
  logic [CW-1:0]               sph_center [3];
  logic [rsi_pkg::DistW-1:0]   sph_radius;

  hit_res_t             pending_hits[$];
  int                   n_errors = 0;
  int                   n_cycles = 0;
  bit                   no_idle = 1'b0;
  bit                   hold_req = 1'b0;

  ray_sphere_intersect_unit i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #2 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles >= CycleLim) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // True when q / 2^FB is at or below the nearer root (s - sqrt(D)) / a.
  function automatic bit root_reaches(logic [32:0] q, wide_t s, wide_t a, wide_t d2);
    wide_t rr;
    rr = (s <<< FB) - wide_t'(q) * a;
    if (rr < 0) return 1'b0;
    return (rr * rr) >= d2;
  endfunction

  // Exact intersection of one ray with the current sphere.
  function automatic hit_res_t calc_hit_distance(ray_t ray);
    wide_t     a, h, c, dv, w, s, disc, d2, rad;
    logic [32:0] lo, hi, mid;
    hit_res_t  r;
    r = '0;
    a = 0;
    h = 0;
    c = 0;
    for (int i = 0; i < 3; i++) begin
      dv = wide_t'($signed(ray[3+i]));
      w  = wide_t'($signed(ray[i])) - wide_t'($signed(sph_center[i]));
      a += dv * dv;
      h += dv * w;
      c += w * w;
    end
    rad = wide_t'({1'b0, sph_radius});
    c -= rad * rad;
    // Zero direction, origin inside or on the sphere, sphere behind the ray.
    if (a == 0 || c <= 0 || h >= 0) return r;
    disc = h * h - a * c;
    if (disc < 0) return r;
    s  = -h;
    d2 = disc <<< (2 * FB);
    r.hit = 1'b1;
    if (root_reaches({1'b0, IntMax} + 33'd1, s, a, d2)) begin
      r.distance = rsi_pkg::DistMax;
      r.sat      = 1'b1;
      return r;
    end
    lo = 0;
    hi = {1'b0, IntMax} + 33'd1;
    while (hi - lo > 1) begin
      mid = lo + ((hi - lo) >> 1);
      if (root_reaches(mid, s, a, d2)) lo = mid;
      else hi = mid;
    end
    r.distance = lo[rsi_pkg::DistW-1:0];
    return r;
  endfunction

  // Result checker: compare every output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    hit_res_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: expected no result, actual hit=%0b tdata=%h", $time, m_axis_tuser,
                 m_axis_tdata);
        n_errors++;
      end else begin
        exp_r = pending_hits.pop_front();
        if (m_axis_tuser !== exp_r.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[rsi_pkg::DistW-1:0] !== exp_r.distance) begin
          $display("%0t: distance expected %h actual %h", $time, exp_r.distance,
                   m_axis_tdata[rsi_pkg::DistW-1:0]);
          n_errors++;
        end
        if (m_axis_tdata[rsi_pkg::DistW] !== exp_r.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_r.sat,
                   m_axis_tdata[rsi_pkg::DistW]);
          n_errors++;
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int  n;
    bit  ok;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      n = no_idle ? 0 : $urandom_range(0, 6);
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      forever begin
        @(negedge clk_i);
        ok = m_axis_tvalid;
        @(posedge clk_i);
        if (ok) break;
      end
    end
  end

  // Send one ray and record its expected result at the accepting edge.
  task automatic send_ray(ray_t ray);
    int n;
    bit ok;
    n = no_idle ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ray;
    forever begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
      if (ok) break;
    end
    pending_hits.push_back(calc_hit_distance(ray));
  endtask

  task automatic check_known(ray_row_t row);
    hit_res_t p;
    p = calc_hit_distance(row.ray);
    if (row.known && p !== row.res) begin
      $display("%0t: table row expected %h, model gives %h", $time, row.res, p);
      n_errors++;
    end
  endtask

  // Register write; only issued while no ray is in flight.
  task automatic write_reg(rsi_pkg::cfg_reg_e idx, logic [CW-1:0] val);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
      if (ok) break;
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      rsi_pkg::RegCenterX: sph_center[0] = val;
      rsi_pkg::RegCenterY: sph_center[1] = val;
      rsi_pkg::RegCenterZ: sph_center[2] = val;
      default:             sph_radius = val[rsi_pkg::DistW-1:0];
    endcase
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (LatencyC + 10) @(posedge clk_i);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    return $signed($urandom) >>> $urandom_range(0, 31);
  endfunction

  function automatic ray_row_t mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                  bit known = 0, bit hit = 0, int dst = 0, bit sat = 0);
    ray_row_t r;
    r.ray   = {dz, dy, dx, oz, oy, ox};
    r.known = known;
    r.res   = '{hit: hit, distance: dst[rsi_pkg::DistW-1:0], sat: sat};
    return r;
  endfunction

  // Random ray: mostly aimed near the sphere, the rest arbitrary.
  function automatic ray_t rand_ray();
    ray_t        r;
    logic [CW-1:0] off;
    if ($urandom_range(0, 9) < 7) begin
      for (int i = 0; i < 3; i++) begin
        off      = $signed($urandom) >>> $urandom_range(4, 24);
        r[i]     = sph_center[i] + off;
        r[3+i]   = ($signed(-off) >>> $urandom_range(0, 8))
                   + ($signed($urandom) >>> $urandom_range(18, 31));
      end
    end else begin
      for (int i = 0; i < 6; i++) r[i] = ($urandom_range(0, 1)) ? $urandom : rand_coord();
    end
    return r;
  endfunction

  initial begin
    ray_row_t dir_tab[$];

    sph_center = '{0, 0, 0};
    sph_radius = 31'(Q);

    // Directed rays under the reset sphere (center at the origin, radius 1.0).
    dir_tab.push_back(mk(0, 0, 5*Q, 0, 0, 0, 1));                 // zero direction
    dir_tab.push_back(mk(0, 0, 0, Q, 0, 0, 1));                   // origin inside
    dir_tab.push_back(mk(Q, 0, 0, Q, 0, 0, 1));                   // origin on the surface
    dir_tab.push_back(mk(0, 0, 5*Q, 0, 0, Q, 1));                 // sphere behind the ray
    dir_tab.push_back(mk(5*Q, 5*Q, -5*Q, 0, 0, Q, 1));            // negative discriminant
    dir_tab.push_back(mk(0, 0, -5*Q, 0, 0, Q, 1, 1, 4*Q));        // plain hit
    dir_tab.push_back(mk(0, 0, 5*Q, 0, 0, -Q, 1, 1, 4*Q));        // hit along -z
    dir_tab.push_back(mk(Q, 0, -5*Q, 0, 0, Q, 1, 1, 5*Q));        // tangent ray
    dir_tab.push_back(mk(0, 0, -32767*Q, 0, 0, 1, 1, 1, IntMax, 1)); // saturation
    dir_tab.push_back(mk(0, 0, -2*Q, 0, 0, IntMax));              // tiny root
    dir_tab.push_back(mk(0, -2*Q, 0, 0, IntMax, 0));
    dir_tab.push_back(mk(3*Q, 4*Q, -10*Q, -Q, -2*Q, 5*Q));
    dir_tab.push_back(mk(IntMax, IntMax, IntMax, IntMin, IntMin, IntMin));
    dir_tab.push_back(mk(IntMin, IntMin, IntMin, IntMax, IntMax, IntMax));
    dir_tab.push_back(mk(IntMin, IntMin, IntMin, IntMin, IntMin, IntMin));
    dir_tab.push_back(mk(IntMax, IntMax, IntMax, IntMax, IntMax, IntMax));
    dir_tab.push_back(mk(-1, -1, -1, 1, 1, 1));
    dir_tab.push_back(mk(-2*Q, 0, 0, 1, 0, 0));
    dir_tab.push_back(mk(IntMin, 0, 0, IntMax, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      check_known(dir_tab[k]);
      send_ray(dir_tab[k].ray);
    end
    drain();

    // Random phases; the first two use the extreme sphere settings.
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) begin
        write_reg(rsi_pkg::RegCenterX, IntMax);
        write_reg(rsi_pkg::RegCenterY, IntMax);
        write_reg(rsi_pkg::RegCenterZ, IntMax);
        write_reg(rsi_pkg::RegRadius, 32'hffff_ffff);
      end else if (ph == 1) begin
        write_reg(rsi_pkg::RegCenterX, IntMin);
        write_reg(rsi_pkg::RegCenterY, IntMin);
        write_reg(rsi_pkg::RegCenterZ, IntMin);
        write_reg(rsi_pkg::RegRadius, 32'h0);
      end else begin
        write_reg(rsi_pkg::RegCenterX, rand_coord());
        write_reg(rsi_pkg::RegCenterY, rand_coord());
        write_reg(rsi_pkg::RegCenterZ, rand_coord());
        write_reg(rsi_pkg::RegRadius, ($urandom_range(0, 3) == 0) ? $urandom
                                      : ($urandom >> $urandom_range(6, 20)));
      end
      no_idle = (ph % 4 == 3);
      for (int k = 0; k < 110; k++) begin
        if (ph == 4 && k == 10) hold_req = 1'b1;
        send_ray(rand_ray());
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
